// File: hw/rtl/mcc_pkg.sv
package mcc_pkg;

    // Sequencer states of the table rebuild.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RUN
    } state_t;

    // Register indexes on the configuration port (byte address 4*i).
    localparam logic [1:0] REG_LARGE = 2'd0;
    localparam logic [1:0] REG_MID   = 2'd1;
    localparam logic [1:0] REG_SMALL = 2'd2;

    // Step within one table entry: the three denomination tries, then the write-back.
    localparam logic [1:0] PH_LARGE = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_SMALL = 2'd2;
    localparam logic [1:0] PH_WRITE = 2'd3;

    localparam int          DENOM_W    = 5;
    localparam int          COUNT_W    = 5;
    localparam int          BEST_W     = 6;
    localparam logic [5:0]  UNREACHED  = 6'd63;

    localparam logic [4:0]  RESET_LARGE = 5'd8;
    localparam logic [4:0]  RESET_MID   = 5'd5;
    localparam logic [4:0]  RESET_SMALL = 5'd1;

    // One table entry: least stamp count and the split over the denominations.
    typedef struct packed {
        logic [BEST_W-1:0]  best;
        logic [COUNT_W-1:0] n_large;
        logic [COUNT_W-1:0] n_mid;
        logic [COUNT_W-1:0] n_small;
    } entry_t;

endpackage

// File: hw/rtl/min_coin_change_with_counts.sv
// Channel   Handshake                       Payload
// input     in_valid / in_ready             amount_units
// output    out_valid / out_ready           min_count, count_large, count_mid,
//                                           count_small, reachable
// config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A query clears entry zero and then works through every entry from 1 up to
// the amount: three reads of the table RAM, one per denomination, each checked
// in the following cycle, and one write-back.
// in_ready is high only while the sequencer is idle. Reset clears the control
// state and sets the denominations to 8, 5 and 1; the table RAM is not cleared.
// If the previous result has not been taken, the last step of a query waits.
module min_coin_change_with_counts #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mcc_pkg::DENOM_W-1:0]    amount_units,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mcc_pkg::COUNT_W-1:0]    min_count,
    output logic [mcc_pkg::COUNT_W-1:0]    count_large,
    output logic [mcc_pkg::COUNT_W-1:0]    count_mid,
    output logic [mcc_pkg::COUNT_W-1:0]    count_small,
    output logic                           reachable,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mcc_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int AW    = (IDX_W > DENOM_W) ? IDX_W : DENOM_W;
    localparam int LAST  = TABLE_ENTRIES - 1;

    state_t              state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    amount_reg, amount_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [1:0]          pend_k_reg, pend_k_next;
    entry_t              work_reg, work_next;
    logic                out_valid_reg, out_valid_next;
    entry_t              result_reg, result_next;
    logic                reach_reg, reach_next;

    logic [DENOM_W-1:0]  denom_large_reg, denom_mid_reg, denom_small_reg;

    entry_t              entry_mem [TABLE_ENTRIES];
    entry_t              rd_data_reg;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;

    logic [DENOM_W-1:0]  dv;
    logic [AW-1:0]       src_wide;
    logic                usable;
    logic [BEST_W-1:0]   cand_best;
    logic                better;
    entry_t              work_eval;
    logic                slot_free;
    logic                cfg_wr;
    logic [IDX_W-1:0]    amount_sat;
    entry_t              zero_entry;
    entry_t              empty_entry;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            denom_large_reg <= RESET_LARGE;
            denom_mid_reg   <= RESET_MID;
            denom_small_reg <= RESET_SMALL;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LARGE: denom_large_reg <= pwdata[DENOM_W-1:0];
                REG_MID:   denom_mid_reg   <= pwdata[DENOM_W-1:0];
                REG_SMALL: denom_small_reg <= pwdata[DENOM_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LARGE: prdata = {{(32-DENOM_W){1'b0}}, denom_large_reg};
            REG_MID:   prdata = {{(32-DENOM_W){1'b0}}, denom_mid_reg};
            REG_SMALL: prdata = {{(32-DENOM_W){1'b0}}, denom_small_reg};
            default:   prdata = '0;
        endcase
    end

    // Table RAM: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // Shared try unit: denomination of this step, its source entry and the check.
    always_comb
    begin
        case (phase_reg)
            PH_LARGE: dv = denom_large_reg;
            PH_MID:   dv = denom_mid_reg;
            PH_SMALL: dv = denom_small_reg;
            default:  dv = '0;
        endcase
    end

    assign src_wide  = AW'(idx_reg) - AW'(dv);
    assign usable    = (dv != '0) && (AW'(dv) <= AW'(idx_reg)) && (phase_reg != PH_WRITE);
    assign cand_best = rd_data_reg.best + BEST_W'(1);
    // An unreachable source cannot improve an entry; ties keep the earlier try.
    assign better    = pend_valid_reg && (rd_data_reg.best != UNREACHED)
                       && (cand_best < work_reg.best);

    always_comb
    begin
        work_eval = work_reg;
        if (better)
        begin
            work_eval      = rd_data_reg;
            work_eval.best = cand_best;
            case (pend_k_reg)
                PH_LARGE: work_eval.n_large = rd_data_reg.n_large + COUNT_W'(1);
                PH_MID:   work_eval.n_mid   = rd_data_reg.n_mid + COUNT_W'(1);
                default:  work_eval.n_small = rd_data_reg.n_small + COUNT_W'(1);
            endcase
        end
    end

    always_comb
    begin
        if (int'(amount_units) > LAST)
        begin
            amount_sat = IDX_W'(LAST);
        end
        else
        begin
            amount_sat = IDX_W'(amount_units);
        end
    end

    assign zero_entry  = '0;
    assign empty_entry = '{best: UNREACHED, n_large: '0, n_mid: '0, n_small: '0};
    assign slot_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_LARGE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg <= amount_next;
        pend_k_reg <= pend_k_next;
        work_reg   <= work_next;
        result_reg <= result_next;
        reach_reg  <= reach_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        amount_next     = amount_reg;
        pend_valid_next = 1'b0;
        pend_k_next     = phase_reg;
        work_next       = work_reg;
        result_next     = result_reg;
        reach_next      = reach_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = work_eval;
        rd_en           = 1'b0;
        rd_addr         = IDX_W'(src_wide);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    amount_next = amount_sat;
                    state_next  = ST_CLEAR;
                end
            end

            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = zero_entry;
                if (amount_reg == '0)
                begin
                    if (slot_free)
                    begin
                        result_next    = zero_entry;
                        reach_next     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = IDX_W'(1);
                    work_next  = empty_entry;
                    phase_next = PH_LARGE;
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                // Each cycle checks the read result held in rd_data_reg, flagged by pend_valid_reg.
                work_next = work_eval;
                if (phase_reg != PH_WRITE)
                begin
                    rd_en           = usable;
                    pend_valid_next = usable;
                    phase_next      = phase_reg + 2'd1;
                end
                else if (idx_reg == amount_reg)
                begin
                    // Hold the final step until the output register is free.
                    pend_valid_next = pend_valid_reg;
                    pend_k_next     = pend_k_reg;
                    work_next       = work_reg;
                    if (slot_free)
                    begin
                        wr_en          = 1'b1;
                        result_next    = work_eval;
                        reach_next     = (work_eval.best != UNREACHED);
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    idx_next   = idx_reg + IDX_W'(1);
                    work_next  = empty_entry;
                    phase_next = PH_LARGE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign reachable   = reach_reg;
    assign min_count   = reach_reg ? result_reg.best[COUNT_W-1:0] : '0;
    assign count_large = reach_reg ? result_reg.n_large : '0;
    assign count_mid   = reach_reg ? result_reg.n_mid : '0;
    assign count_small = reach_reg ? result_reg.n_small : '0;

endmodule
